// ----- hw/rtl/pmide_pkg.sv -----
// ----------------------------------------------------------------------------
// pmide_pkg
// Shared types and codes for the mode-0 parallel port / IDE bank interface.
// ----------------------------------------------------------------------------
package pmide_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // configuration register index (paddr[2])
    localparam logic CFG_ACTIVE = 1'b0;

    // request opcodes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_RETURN = 2'd2;

    // port selects
    localparam logic [1:0] SEL_A    = 2'd0;
    localparam logic [1:0] SEL_B    = 2'd1;
    localparam logic [1:0] SEL_C    = 2'd2;
    localparam logic [1:0] SEL_CTRL = 2'd3;

    // IDE request codes
    localparam logic [1:0] IDE_NONE  = 2'd0;
    localparam logic [1:0] IDE_READ  = 2'd1;
    localparam logic [1:0] IDE_WRITE = 2'd2;

    // control word bits
    localparam int CW_C_LOW  = 0;
    localparam int CW_B      = 1;
    localparam int CW_C_HIGH = 3;
    localparam int CW_A      = 4;
    localparam int CW_MODE   = 7;

    localparam logic [7:0] CW_RESET   = 8'h9b;
    localparam logic [7:0] PORT_RESET = 8'hff;

    // port C decode
    localparam logic [7:0] PRI_MASK   = 8'h78;
    localparam logic [7:0] PRI_RD     = 8'h30;
    localparam logic [7:0] PRI_WR     = 8'h28;
    localparam logic [7:0] SEC_MASK   = 8'hd8;
    localparam logic [7:0] SEC_RD     = 8'h90;
    localparam logic [7:0] SEC_WR     = 8'h88;
    localparam int         LATCH_BIT  = 6;
    localparam int         PAGE_OFF   = 7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  port_select;
        logic [7:0]  write_data;
        logic [15:0] ide_read_data;
    } item_t;

    typedef struct packed {
        logic [7:0] control_word;
        logic [7:0] port_a;
        logic [7:0] port_b;
        logic [7:0] port_c;
        logic [2:0] pending_register;
        logic [4:0] bank_number;
        logic       rom_paged;
    } state_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        attached;
        logic [1:0]  ide_request;
        logic        ide_channel;
        logic [2:0]  ide_register;
        logic [15:0] ide_write_data;
        logic        bank_latched;
        logic [4:0]  ram_bank;
        logic        rom_paged_in;
    } result_t;

endpackage

// ----- hw/rtl/pmide_cfg.sv -----
// ----------------------------------------------------------------------------
// pmide_cfg
// APB register slave holding the interface enable bit.
// ----------------------------------------------------------------------------
module pmide_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmide_pkg::PADDR_W-1:0] paddr,
    input  logic [pmide_pkg::PDATA_W-1:0] pwdata,
    output logic [pmide_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output logic                          active
);

    logic active_reg;
    logic active_next;
    logic wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr[2] == pmide_pkg::CFG_ACTIVE);

    always_comb
    begin
        active_next = active_reg;
        if (wr_hit)
        begin
            active_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign pready = 1'b1;
    assign active = active_reg;
    assign prdata = (paddr[2] == pmide_pkg::CFG_ACTIVE)
                  ? {{(pmide_pkg::PDATA_W-1){1'b0}}, active_reg}
                  : '0;

endmodule

// ----- hw/rtl/pmide_core.sv -----
// ----------------------------------------------------------------------------
// pmide_core
// Port logic for one request: returns the next port state and the result.
// ----------------------------------------------------------------------------
module pmide_core
(
    input  logic              active,
    input  pmide_pkg::item_t  item,
    input  pmide_pkg::state_t st,
    output pmide_pkg::state_t ns,
    output pmide_pkg::result_t res
);

    function automatic logic rd_pri(input logic [7:0] c);
        return (c & pmide_pkg::PRI_MASK) == pmide_pkg::PRI_RD;
    endfunction

    function automatic logic wr_pri(input logic [7:0] c);
        return (c & pmide_pkg::PRI_MASK) == pmide_pkg::PRI_WR;
    endfunction

    function automatic logic rd_sec(input logic [7:0] c);
        return (c & pmide_pkg::SEC_MASK) == pmide_pkg::SEC_RD;
    endfunction

    function automatic logic wr_sec(input logic [7:0] c);
        return (c & pmide_pkg::SEC_MASK) == pmide_pkg::SEC_WR;
    endfunction

    logic       c_wr;
    logic [7:0] c_data;
    logic [7:0] c_bsr;
    logic [7:0] nc;
    logic [7:0] cw;
    logic       rp;
    logic       rs;
    logic       wp;
    logic       ws;

    assign cw = st.control_word;

    always_comb
    begin
        ns     = st;
        res    = '0;
        c_wr   = 1'b0;
        c_data = item.write_data;
        c_bsr  = st.port_c;
        c_bsr[item.write_data[3:1]] = item.write_data[0];

        unique case (item.opcode)
            pmide_pkg::OP_READ:
            begin
                if (!active)
                begin
                    res.read_data = 8'hff;
                end
                else
                begin
                    res.attached = 1'b1;
                    unique case (item.port_select)
                        pmide_pkg::SEL_A:    res.read_data = st.port_a;
                        pmide_pkg::SEL_B:    res.read_data = st.port_b;
                        pmide_pkg::SEL_C:    res.read_data = st.port_c;
                        pmide_pkg::SEL_CTRL: res.read_data = cw;
                        default:             res.read_data = cw;
                    endcase
                end
            end
            pmide_pkg::OP_WRITE:
            begin
                if (active)
                begin
                    unique case (item.port_select)
                        pmide_pkg::SEL_A:
                        begin
                            if (!cw[pmide_pkg::CW_A])
                            begin
                                ns.port_a = item.write_data;
                            end
                        end
                        pmide_pkg::SEL_B:
                        begin
                            if (!cw[pmide_pkg::CW_B])
                            begin
                                ns.port_b = item.write_data;
                            end
                        end
                        pmide_pkg::SEL_C:
                        begin
                            c_wr = 1'b1;
                        end
                        default:
                        begin
                            if (item.write_data[pmide_pkg::CW_MODE])
                            begin
                                // mode set also reinitializes the ports
                                ns.control_word = item.write_data;
                                ns.port_a = {8{item.write_data[pmide_pkg::CW_A]}};
                                ns.port_b = {8{item.write_data[pmide_pkg::CW_B]}};
                                ns.port_c = {{4{item.write_data[pmide_pkg::CW_C_HIGH]}},
                                             {4{item.write_data[pmide_pkg::CW_C_LOW]}}};
                            end
                            else
                            begin
                                // single-bit set/reset goes through the port C path
                                c_wr   = 1'b1;
                                c_data = c_bsr;
                            end
                        end
                    endcase
                end
            end
            pmide_pkg::OP_RETURN:
            begin
                if (active)
                begin
                    if (cw[pmide_pkg::CW_A])
                    begin
                        ns.port_a = item.ide_read_data[7:0];
                    end
                    if (cw[pmide_pkg::CW_B])
                    begin
                        ns.port_b = (st.pending_register == 3'd0)
                                  ? item.ide_read_data[15:8] : 8'hff;
                    end
                end
            end
            default:
            begin
            end
        endcase

        nc = {cw[pmide_pkg::CW_C_HIGH] ? st.port_c[7:4] : c_data[7:4],
              cw[pmide_pkg::CW_C_LOW]  ? st.port_c[3:0] : c_data[3:0]};
        rp = rd_pri(nc) && !rd_pri(st.port_c);
        rs = rd_sec(nc) && !rd_sec(st.port_c);
        wp = wr_pri(nc) && !wr_pri(st.port_c);
        ws = wr_sec(nc) && !wr_sec(st.port_c);

        if (c_wr)
        begin
            ns.port_c = nc;
            if (!cw[pmide_pkg::CW_C_HIGH])
            begin
                priority if (rp || rs)
                begin
                    ns.pending_register = nc[2:0];
                    res.ide_request  = pmide_pkg::IDE_READ;
                    res.ide_channel  = !rp;
                    res.ide_register = nc[2:0];
                end
                else if (wp || ws)
                begin
                    res.ide_request    = pmide_pkg::IDE_WRITE;
                    res.ide_channel    = !wp;
                    res.ide_register   = nc[2:0];
                    res.ide_write_data = {cw[pmide_pkg::CW_B] ? 8'hff : st.port_b,
                                          cw[pmide_pkg::CW_A] ? 8'hff : st.port_a};
                end
                else if (nc[pmide_pkg::LATCH_BIT])
                begin
                    ns.bank_number   = nc[4:0];
                    ns.rom_paged     = !nc[pmide_pkg::PAGE_OFF];
                    res.bank_latched = 1'b1;
                end
                else
                begin
                end
            end
        end

        res.ram_bank     = ns.bank_number;
        res.rom_paged_in = ns.rom_paged;
    end

endmodule

// ----- hw/rtl/ppi_mode0_ide_bank_interface.sv -----
// ----------------------------------------------------------------------------
// ppi_mode0_ide_bank_interface
// Mode-0 parallel port front end for an IDE interface with RAM banking.
// ----------------------------------------------------------------------------
// Each request passes through an input register, one stage of port logic and
// a result register. One request is taken every clock unless the result is
// stalled; the single port-logic stage reads and updates the port latches. A
// stalled result holds in the result register while the next request waits
// in the input register. The interface is disabled after reset until the
// active register is written through the APB port.
module ppi_mode0_ide_bank_interface
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmide_pkg::PADDR_W-1:0] paddr,
    input  logic [pmide_pkg::PDATA_W-1:0] pwdata,
    output logic [pmide_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [1:0]                    port_select,
    input  logic [7:0]                    write_data,
    input  logic [15:0]                   ide_read_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    read_data,
    output logic                          attached,
    output logic [1:0]                    ide_request,
    output logic                          ide_channel,
    output logic [2:0]                    ide_register,
    output logic [15:0]                   ide_write_data,
    output logic                          bank_latched,
    output logic [4:0]                    ram_bank,
    output logic                          rom_paged_in
);

    logic                active;
    logic                in_vld_reg;
    logic                out_vld_reg;
    logic                advance;
    logic                fire;
    logic                take;
    pmide_pkg::item_t    item_reg;
    pmide_pkg::item_t    item_next;
    pmide_pkg::state_t   state_reg;
    pmide_pkg::state_t   state_next;
    pmide_pkg::result_t  res_reg;
    pmide_pkg::result_t  res_next;

    pmide_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .active  (active)
    );

    pmide_core u_core
    (
        .active (active),
        .item   (item_reg),
        .st     (state_reg),
        .ns     (state_next),
        .res    (res_next)
    );

    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign take     = in_valid && !in_stall;

    assign item_next = '{opcode:        opcode,
                         port_select:   port_select,
                         write_data:    write_data,
                         ide_read_data: ide_read_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '{control_word:     pmide_pkg::CW_RESET,
                             port_a:           pmide_pkg::PORT_RESET,
                             port_b:           pmide_pkg::PORT_RESET,
                             port_c:           pmide_pkg::PORT_RESET,
                             pending_register: 3'd0,
                             bank_number:      5'd0,
                             rom_paged:        1'b0};
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign read_data      = res_reg.read_data;
    assign attached       = res_reg.attached;
    assign ide_request    = res_reg.ide_request;
    assign ide_channel    = res_reg.ide_channel;
    assign ide_register   = res_reg.ide_register;
    assign ide_write_data = res_reg.ide_write_data;
    assign bank_latched   = res_reg.bank_latched;
    assign ram_bank       = res_reg.ram_bank;
    assign rom_paged_in   = res_reg.rom_paged_in;

endmodule

// ----- hw/rtl/pmide_checker.sv -----
// ----------------------------------------------------------------------------
// pmide_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pmide_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  read_data,
    input logic        attached,
    input logic [1:0]  ide_request,
    input logic        ide_channel,
    input logic [2:0]  ide_register,
    input logic [15:0] ide_write_data,
    input logic        bank_latched,
    input logic [4:0]  ram_bank,
    input logic        rom_paged_in
);

    // stalled request keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(ide_request) && $stable(ide_write_data) && $stable(ram_bank)
            && $stable(rom_paged_in))
        else $error("result changed while stalled");

    // a read answer never carries an IDE action or bank latch
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && attached |-> ide_request == pmide_pkg::IDE_NONE && !bank_latched)
        else $error("read result carries side action");

    a_no_ide_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ide_request == pmide_pkg::IDE_NONE
            |-> ide_channel == 1'b0 && ide_register == 3'd0 && ide_write_data == 16'd0)
        else $error("IDE fields set without IDE request");

    a_ide_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ide_request == pmide_pkg::IDE_READ |-> ide_write_data == 16'd0)
        else $error("IDE read start carries write data");

    a_latch_rom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bank_latched |-> ide_request == pmide_pkg::IDE_NONE
            && read_data == 8'd0)
        else $error("bank latch mixed with other action");

endmodule

bind ppi_mode0_ide_bank_interface pmide_checker u_pmide_checker (.*);
